>>> src/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int unsigned MAX_FRAME_DEFAULT = 32;
   localparam logic [15:0] HEADER_WORD_RESET = 16'h424D;

   // Frame layout: header bytes, then length bytes end the prefix, checksum bytes trail
   localparam int unsigned HEADER_BYTES = 2;
   localparam int unsigned PREFIX_BYTES = 4;
   localparam int unsigned MIN_LENGTH   = 2;

   localparam logic [1:0] STATUS_GOOD       = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH   = 2'd1;
   localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;

   typedef struct packed {
      logic [1:0]  frame_status;
      logic [15:0] frame_length;
      logic [15:0] computed_sum;
      logic [15:0] received_sum;
   } sfr_result_type;

endpackage

>>> src/sfr_channels.sv
`timescale 1ns / 1ps

interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  frame_status;
   logic [15:0] frame_length;
   logic [15:0] computed_sum;
   logic [15:0] received_sum;

   modport source (output valid, output frame_status, output frame_length,
                   output computed_sum, output received_sum, input ready);
   modport sink (input valid, input frame_status, input frame_length,
                 input computed_sum, input received_sum, output ready);
endinterface

>>> src/sfr_parser.sv
`timescale 1ns / 1ps

module sfr_parser #(
   parameter int unsigned MAX_FRAME = sfr_pkg::MAX_FRAME_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             rx_byte,
   input  logic [15:0]            header_word,
   output logic                   result_valid,
   output sfr_pkg::sfr_result_type result
);
   import sfr_pkg::*;

   localparam int unsigned POS_WIDTH = $clog2(MAX_FRAME + 1);
   localparam logic [16:0] MAX_FRAME_WORD = 17'(MAX_FRAME);

   logic                 locked_ff, locked_in;
   logic [POS_WIDTH-1:0] pos_ff, pos_in;
   logic [15:0]          header_shift_ff, header_shift_in;
   logic [15:0]          length_ff, length_in;
   logic [15:0]          sum_ff, sum_in;
   logic [15:0]          checksum_ff, checksum_in;
   logic [16:0]          pos_word;
   logic [16:0]          length_word;

   assign pos_word    = 17'(pos_ff);
   assign length_word = {1'b0, length_ff};

   always_comb begin
      locked_in       = locked_ff;
      pos_in          = pos_ff;
      header_shift_in = header_shift_ff;
      length_in       = length_ff;
      sum_in          = sum_ff;
      checksum_in     = checksum_ff;
      result_valid    = 1'b0;
      result          = '0;

      if (!locked_ff) begin
         // hunt: slide bytes through the header window
         header_shift_in = {header_shift_ff[7:0], rx_byte};
         if (pos_ff < POS_WIDTH'(HEADER_BYTES)) begin
            pos_in = pos_ff + POS_WIDTH'(1);
         end
         if (pos_in == POS_WIDTH'(HEADER_BYTES) && header_shift_in == header_word) begin
            locked_in   = 1'b1;
            sum_in      = {8'h00, header_shift_in[15:8]} + {8'h00, header_shift_in[7:0]};
            length_in   = '0;
            checksum_in = '0;
         end
      end else if (pos_ff < POS_WIDTH'(PREFIX_BYTES)) begin
         // length bytes, big-endian
         length_in = {length_ff[7:0], rx_byte};
         sum_in    = sum_ff + {8'h00, rx_byte};
         pos_in    = pos_ff + POS_WIDTH'(1);
         if (pos_in == POS_WIDTH'(PREFIX_BYTES) &&
             (length_in < 16'(MIN_LENGTH) ||
              ({1'b0, length_in} + 17'(PREFIX_BYTES)) > MAX_FRAME_WORD)) begin
            result_valid        = 1'b1;
            result.frame_status = STATUS_BAD_LENGTH;
            result.frame_length = length_in;
            result.computed_sum = sum_in;
            result.received_sum = '0;
         end
      end else begin
         // length is known good here, so the frame fits the position counter
         if (pos_word < length_word + 17'(HEADER_BYTES)) begin
            sum_in = sum_ff + {8'h00, rx_byte};
         end else if (pos_word == length_word + 17'(HEADER_BYTES)) begin
            checksum_in = {rx_byte, 8'h00};
         end else begin
            checksum_in = {checksum_ff[15:8], rx_byte};
         end
         pos_in = pos_ff + POS_WIDTH'(1);
         if (pos_word + 17'd1 >= length_word + 17'(PREFIX_BYTES)) begin
            result_valid        = 1'b1;
            result.frame_status = (sum_in == checksum_in) ? STATUS_GOOD : STATUS_MISMATCH;
            result.frame_length = length_ff;
            result.computed_sum = sum_in;
            result.received_sum = checksum_in;
         end
      end

      // any result drops back to a fresh hunt
      if (result_valid) begin
         locked_in       = 1'b0;
         pos_in          = '0;
         header_shift_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff       <= 1'b0;
         pos_ff          <= '0;
         header_shift_ff <= '0;
         length_ff       <= '0;
         sum_ff          <= '0;
         checksum_ff     <= '0;
      end else if (step) begin
         locked_ff       <= locked_in;
         pos_ff          <= pos_in;
         header_shift_ff <= header_shift_in;
         length_ff       <= length_in;
         sum_ff          <= sum_in;
         checksum_ff     <= checksum_in;
      end
   end

endmodule

>>> src/sensor_frame_receiver.sv
`timescale 1ns / 1ps
// The last frame byte waits in the input register until the parser takes it; its frame
// status is then loaded into the result register, which presents it on rsp.
// Throughput: one byte per cycle; the only stall is a result held by rsp.ready low.
// Reset (synchronous, active high) returns to hunting with all frame state cleared
// and header_word back to 0x424D.

module sensor_frame_receiver #(
   parameter int unsigned MAX_FRAME = sfr_pkg::MAX_FRAME_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   sfr_req_if.sink     req_chan,
   sfr_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import sfr_pkg::*;

   // Input register: one received byte waiting for the parser
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // Result register: one frame status waiting to be taken
   logic           rsp_valid_ff, rsp_valid_in;
   sfr_result_type rsp_data_ff;

   logic [15:0]    header_word_ff;

   logic           advance;
   logic           res_valid;
   sfr_result_type res_data;

   // The parser consumes the held byte whenever the result register has room
   // for whatever this byte may produce.
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_chan.valid || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && res_valid) || (rsp_valid_ff && !rsp_chan.ready);

   sfr_parser #(
      .MAX_FRAME(MAX_FRAME)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .rx_byte      (in_byte_ff),
      .header_word  (header_word_ff),
      .result_valid (res_valid),
      .result       (res_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         header_word_ff <= HEADER_WORD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            header_word_ff <= csr_write_data;
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance && res_valid) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_status = rsp_data_ff.frame_status;
   assign rsp_chan.frame_length = rsp_data_ff.frame_length;
   assign rsp_chan.computed_sum = rsp_data_ff.computed_sum;
   assign rsp_chan.received_sum = rsp_data_ff.received_sum;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import sfr_pkg::*;

   // Frame limits follow the block's default build
   localparam int unsigned MAX_FRAME    = MAX_FRAME_DEFAULT;
   localparam int unsigned MAX_LENGTH   = MAX_FRAME - PREFIX_BYTES;
   localparam int unsigned ITEM_TARGET  = 1350;
   localparam int unsigned IDLE_PCT     = 25;    // idle cycles per hundred, each side
   localparam int unsigned QUIET_CYCLES = 4;     // covers input reg + result reg
   localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int unsigned STALL_LIMIT  = 3000;  // cycles with no handshake at all

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   sfr_req_if req_bus();
   sfr_rsp_if rsp_bus();

   sensor_frame_receiver dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Frame tracker: mirrors the receiver state byte by byte and queues the
   // status each accepted byte is due to produce.
   // ---------------------------------------------------------------------
   logic [15:0] header_cfg;
   logic        in_frame;
   logic [8:0]  frame_pos;
   logic [15:0] shift_reg;
   logic [15:0] length_reg;
   logic [15:0] sum_reg;
   logic [15:0] cksum_reg;

   sfr_result_type status_due[$];

   // Test bookkeeping
   bit          steady_run;      // no idling on either side
   int unsigned rsp_hold_left;   // receiver hold-off, counted down by the receiver
   int unsigned items_sent;
   int unsigned header_writes;
   int unsigned mismatch_count;
   int unsigned status_count[3];
   int unsigned stalled_cycles;

   function automatic void close_frame(input logic [1:0] status, input logic [15:0] rsum);
      status_due.push_back('{frame_status: status, frame_length: length_reg,
                             computed_sum: sum_reg, received_sum: rsum});
      // back to hunting; two fresh bytes needed before the next lock
      in_frame  = 1'b0;
      frame_pos = '0;
      shift_reg = '0;
   endfunction

   function automatic void predict_frame_byte(input logic [7:0] rx);
      int unsigned p;
      if (!in_frame) begin
         shift_reg = {shift_reg[7:0], rx};
         if (frame_pos < HEADER_BYTES)
            frame_pos++;
         if (frame_pos == HEADER_BYTES && shift_reg == header_cfg) begin
            in_frame   = 1'b1;
            sum_reg    = 16'(shift_reg[15:8]) + 16'(shift_reg[7:0]);
            length_reg = '0;
            cksum_reg  = '0;
         end
         return;
      end
      p = frame_pos;
      if (p < PREFIX_BYTES) begin
         length_reg = {length_reg[7:0], rx};
         sum_reg    = sum_reg + 16'(rx);
         frame_pos  = 9'(p + 1);
         // length is judged as soon as its low byte lands
         if (frame_pos == PREFIX_BYTES &&
             (length_reg < MIN_LENGTH || length_reg + PREFIX_BYTES > MAX_FRAME))
            close_frame(STATUS_BAD_LENGTH, 16'd0);
         return;
      end
      if (p < length_reg + 2)
         sum_reg = sum_reg + 16'(rx);
      else if (p == length_reg + 2)
         cksum_reg = {rx, 8'h00};
      else
         cksum_reg = {cksum_reg[15:8], rx};
      frame_pos = 9'(p + 1);
      if (p + 1 >= length_reg + PREFIX_BYTES)
         close_frame((sum_reg == cksum_reg) ? STATUS_GOOD : STATUS_MISMATCH, cksum_reg);
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: every accepted status against the oldest one due.
   // ---------------------------------------------------------------------
   function automatic void compare_field(input string field, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      sfr_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (status_due.size() == 0) begin
            $error("frame status 0x%0h arrived with none due", rsp_bus.frame_status);
            mismatch_count++;
         end else begin
            want = status_due.pop_front();
            compare_field("frame_status", want.frame_status, rsp_bus.frame_status);
            compare_field("frame_length", want.frame_length, rsp_bus.frame_length);
            compare_field("computed_sum", want.computed_sum, rsp_bus.computed_sum);
            compare_field("received_sum", want.received_sum, rsp_bus.received_sum);
            if (want.frame_status <= STATUS_BAD_LENGTH)
               status_count[want.frame_status]++;
         end
      end
   end

   // Receiver: random ready, always ready in steady runs, and a long hold-off on request that overrides both
   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_bus.ready = 1'b0;
         rsp_hold_left--;
      end else if (steady_run) begin
         rsp_bus.ready = 1'b1;
      end else begin
         rsp_bus.ready = ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog: a run with no handshake for too long is hung
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake in %0d cycles, %0d statuses outstanding",
                     stalled_cycles, status_due.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender side. Tasks start and end on a falling edge.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      gap = 0;
      if (!steady_run)
         while ($urandom_range(99) < IDLE_PCT)
            gap++;
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid   = 1'b1;
      req_bus.rx_byte = value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_frame_byte(value);
      items_sent++;
      @(negedge clock);
   endtask

   // Header, length, payload and checksum for the current header word.
   // A bad length ends the frame after the prefix. sum_flip spoils the
   // checksum; cut, when nonzero, stops the frame after that many bytes.
   task automatic send_frame(input logic [15:0] len, input logic [15:0] sum_flip,
                             input int unsigned cut);
      logic [7:0]  fb[$];
      logic [15:0] sum;
      int unsigned last;
      fb = '{header_cfg[15:8], header_cfg[7:0], len[15:8], len[7:0]};
      if (len >= MIN_LENGTH && len <= MAX_LENGTH) begin
         for (int i = 0; i < len - MIN_LENGTH; i++)
            fb.push_back(8'($urandom));
         sum = '0;
         foreach (fb[i])
            sum = sum + 16'(fb[i]);
         sum = sum ^ sum_flip;
         fb.push_back(sum[15:8]);
         fb.push_back(sum[7:0]);
      end
      last = (cut != 0 && cut < fb.size()) ? cut : fb.size();
      for (int i = 0; i < last; i++)
         send_byte(fb[i]);
   endtask

   task automatic send_noise(input int unsigned count);
      repeat (count) send_byte(8'($urandom));
   endtask

   function automatic logic [15:0] pick_good_length();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return 16'(MIN_LENGTH);
      if (roll < 20)
         return 16'(MAX_LENGTH);
      return 16'($urandom_range(MIN_LENGTH, MAX_LENGTH));
   endfunction

   // Lets the block go idle: all statuses back, then the pipeline flushed
   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (status_due.size() != 0) @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_header_word(input logic [15:0] word);
      csr_write_enable = 1'b1;
      csr_write_data   = word;
      @(negedge clock);
      csr_write_enable = 1'b0;
      header_cfg       = word;
      header_writes++;
   endtask

   // Mostly frames of good length with random content, some with a spoiled
   // checksum; the rest bad lengths, frames cut short and loose bytes.
   task automatic run_traffic_mix(input int unsigned stop_at);
      int unsigned pick;
      logic [15:0] len;
      logic [15:0] flip;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            len  = pick_good_length();
            flip = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 65535)) : 16'd0;
            send_frame(len, flip, 0);
         end else if (pick < 80) begin
            case ($urandom_range(4))
               0: begin
                  len = 16'd0;
               end
               1: begin
                  len = 16'(MIN_LENGTH - 1);
               end
               2: begin
                  len = 16'(MAX_LENGTH + 1);
               end
               3: begin
                  len = 16'hFFFF;
               end
               default: begin
                  len = 16'($urandom_range(MAX_LENGTH + 2, 65535));
               end
            endcase
            send_frame(len, 16'd0, 0);
         end else if (pick < 90) begin
            len = pick_good_length();
            send_frame(len, 16'd0, $urandom_range(1, len + PREFIX_BYTES - 1));
         end else begin
            send_noise($urandom_range(1, 8));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset header: shortest frame, length limits, resync after a bad
   // length, and trailing bytes that look like a header.
   task automatic test_directed_frames();
      send_frame(16'(MIN_LENGTH), 16'd0, 0);
      send_frame(16'd0, 16'd0, 0);
      // stale header bytes must not count; the lock needs two fresh ones
      send_byte(HEADER_WORD_RESET[7:0]);
      send_byte(HEADER_WORD_RESET[15:8]);
      send_byte(HEADER_WORD_RESET[7:0]);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_frame(16'(MIN_LENGTH - 1), 16'd0, 0);
      send_frame(16'(MAX_LENGTH + 1), 16'd0, 0);
      // checksum bytes equal to the header word: a mismatch, and no relock
      send_byte(HEADER_WORD_RESET[15:8]);
      send_byte(HEADER_WORD_RESET[7:0]);
      send_byte(8'h00);
      send_byte(8'h03);
      send_byte(8'h00);
      send_byte(HEADER_WORD_RESET[15:8]);
      send_byte(HEADER_WORD_RESET[7:0]);
      send_byte(HEADER_WORD_RESET[7:0]);
      drain_results();
   endtask

   // All-zero and all-one header words, and one made of a repeated byte
   task automatic test_header_extremes();
      write_header_word(16'h0000);
      send_frame(16'(MIN_LENGTH), 16'd0, 0);
      send_noise(3);
      send_frame(16'(MAX_LENGTH), 16'd0, 0);
      drain_results();
      write_header_word(16'hFFFF);
      send_frame(16'd3, 16'h8000, 0);
      send_frame(16'd0, 16'd0, 0);
      send_frame(16'(MAX_LENGTH), 16'd0, 0);
      drain_results();
      write_header_word(16'h4D4D);
      send_frame(16'd0, 16'd0, 0);
      send_byte(8'h4D);
      send_frame(16'(MIN_LENGTH), 16'd0, 0);
      send_noise(4);
      drain_results();
   endtask

   // Back-to-back bytes and results, no idling anywhere
   task automatic test_steady_stream();
      write_header_word(16'($urandom));
      steady_run = 1'b1;
      run_traffic_mix(items_sent + 150);
      steady_run = 1'b0;
      drain_results();
   endtask

   // Receiver holds off while the sender keeps offering, so the input stalls;
   // then the sender waits out every status still due.
   task automatic test_result_backpressure();
      steady_run    = 1'b1;
      rsp_hold_left = HOLD_CYCLES;
      repeat (8) send_frame(16'($urandom_range(MIN_LENGTH, 6)), 16'd0, 0);
      steady_run = 1'b0;
      drain_results();
   endtask

   // Bulk traffic over four header settings, the reset value among them
   task automatic test_random_traffic();
      logic [15:0] hdr;
      int unsigned share;
      for (int ph = 0; ph < 4; ph++) begin
         hdr = (ph == 0) ? HEADER_WORD_RESET : 16'($urandom);
         write_header_word(hdr);
         share = (items_sent < ITEM_TARGET) ? (ITEM_TARGET - items_sent) / (4 - ph) : 0;
         run_traffic_mix(items_sent + share);
         drain_results();
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      req_bus.rx_byte  = '0;
      rsp_bus.ready    = 1'b0;
      steady_run       = 1'b0;
      rsp_hold_left    = 0;
      items_sent       = 0;
      header_writes    = 0;
      mismatch_count   = 0;
      stalled_cycles   = 0;
      status_count     = '{0, 0, 0};
      header_cfg       = HEADER_WORD_RESET;
      in_frame         = 1'b0;
      frame_pos        = '0;
      shift_reg        = '0;
      length_reg       = '0;
      sum_reg          = '0;
      cksum_reg        = '0;

      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_directed_frames();
      test_header_extremes();
      test_steady_stream();
      test_result_backpressure();
      test_random_traffic();

      drain_results();
      repeat (8) @(negedge clock);

      $display("Sent %0d bytes under %0d header writes; checked %0d good, %0d mismatch, %0d bad length",
               items_sent, header_writes, status_count[STATUS_GOOD],
               status_count[STATUS_MISMATCH], status_count[STATUS_BAD_LENGTH]);
      if (mismatch_count == 0 && status_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d field errors, %0d statuses never arrived",
                  mismatch_count, status_due.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
